// File: rtl/lab_pkg.sv
`default_nettype none

package lab_pkg;

  // Sizing of the row store and of the score datapath.
  localparam int MAX_COLUMNS = 1024;
  localparam int SCORE_BITS  = 16;
  localparam int COL_BITS    = $clog2(MAX_COLUMNS);

  // Fixed field widths of the ports.
  localparam int LEN_BITS       = 11;
  localparam int GAIN_BITS      = 4;
  localparam int PEN_BITS       = 5;
  localparam int OUT_BITS       = 16;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;

  // Candidate sums carry two extra bits: one for the sign, one for headroom.
  localparam int EXT_BITS = SCORE_BITS + 2;
  localparam logic signed [EXT_BITS-1:0] SCORE_TOP_EXT = {2'b00, {SCORE_BITS{1'b1}}};

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ROW_LENGTH       = 4'd0,
    REG_MATCH_GAIN       = 4'd1,
    REG_MISMATCH_PENALTY = 4'd2,
    REG_GAP_PENALTY      = 4'd3
  } cfg_reg_t;

  // One cell on its way from the address stage to the scoring stage.
  typedef struct packed {
    logic                valid;
    logic [COL_BITS-1:0] col;
    logic                first_row;
    logic                is_match;
    logic                last_cell;
    logic                fwd;
  } lab_item_t;

  // Write-back of a cell score into the row store.
  typedef struct packed {
    logic                  we;
    logic [COL_BITS-1:0]   addr;
    logic [SCORE_BITS-1:0] data;
  } lab_wr_t;

  // Final score of a matrix, handed to the output queue.
  typedef struct packed {
    logic                push;
    logic [OUT_BITS-1:0] value;
  } lab_result_t;

endpackage

`default_nettype wire

// File: rtl/lab_ram.sv
`default_nettype none

module lab_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write to the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/lab_pe.sv
`default_nettype none

module lab_pe (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire lab_pkg::lab_item_t                     item,
  input  wire logic [lab_pkg::SCORE_BITS-1:0]         ram_q,
  input  wire logic [lab_pkg::SCORE_BITS-1:0]         fwd_score,
  input  wire logic [lab_pkg::GAIN_BITS-1:0]          match_gain,
  input  wire logic signed [lab_pkg::PEN_BITS-1:0]    mismatch_penalty,
  input  wire logic signed [lab_pkg::PEN_BITS-1:0]    gap_penalty,
  output      lab_pkg::lab_wr_t                       wr,
  output      lab_pkg::lab_result_t                   result
);

  import lab_pkg::*;

  logic [SCORE_BITS-1:0]      left_score;
  logic [SCORE_BITS-1:0]      diagonal_score;
  logic [SCORE_BITS-1:0]      running_best;

  logic [SCORE_BITS-1:0]      up;
  logic [SCORE_BITS-1:0]      left;
  logic [SCORE_BITS-1:0]      diag;
  logic signed [EXT_BITS-1:0] gap_ext;
  logic signed [EXT_BITS-1:0] step_ext;
  logic signed [EXT_BITS-1:0] cand_up;
  logic signed [EXT_BITS-1:0] cand_left;
  logic signed [EXT_BITS-1:0] cand_diag;
  logic signed [EXT_BITS-1:0] cell_ext;
  logic [SCORE_BITS-1:0]      cell_score;
  logic [SCORE_BITS-1:0]      best_with_cell;

  always_comb begin
    // The row above the first row and the column left of column zero are zero.
    up   = item.first_row ? '0 : (item.fwd ? fwd_score : ram_q);
    left = (item.col == '0) ? '0 : left_score;
    diag = ((item.col == '0) || item.first_row) ? '0 : diagonal_score;

    gap_ext  = EXT_BITS'(gap_penalty);
    step_ext = item.is_match ? signed'(EXT_BITS'(match_gain))
                             : EXT_BITS'(mismatch_penalty);

    cand_up   = signed'({2'b00, up})   + gap_ext;
    cand_left = signed'({2'b00, left}) + gap_ext;
    cand_diag = signed'({2'b00, diag}) + step_ext;

    cell_ext = '0;
    if (cand_up > cell_ext) begin
      cell_ext = cand_up;
    end
    if (cand_left > cell_ext) begin
      cell_ext = cand_left;
    end
    if (cand_diag > cell_ext) begin
      cell_ext = cand_diag;
    end
    if (cell_ext > SCORE_TOP_EXT) begin
      cell_ext = SCORE_TOP_EXT;
    end
    cell_score = cell_ext[SCORE_BITS-1:0];

    best_with_cell = (cell_score > running_best) ? cell_score : running_best;
  end

  always_comb begin
    wr.we   = item.valid;
    wr.addr = item.col;
    wr.data = cell_score;

    result.push  = item.valid && item.last_cell;
    result.value = ((best_with_cell >> OUT_BITS) != '0) ? '1 : OUT_BITS'(best_with_cell);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_score     <= '0;
      diagonal_score <= '0;
      running_best   <= '0;
    end else if (item.valid) begin
      left_score     <= cell_score;
      diagonal_score <= up;
      running_best   <= item.last_cell ? '0 : best_with_cell;
    end
  end

endmodule

`default_nettype wire

// File: rtl/local_alignment_binary_matrix.sv
`default_nettype none

// Streaming Smith-Waterman scorer for a binary similarity matrix, linear gap.
// Input channel (in_valid/in_ready): one beat per matrix cell, row-major,
// carrying is_match and last_cell. Output channel (out_valid/out_ready): one
// beat per matrix, sent after the beat marked last_cell, carrying best_score.
// Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index picks
// row_length, match_gain, mismatch_penalty or gap_penalty; cfg_data is written.
// Throughput is one cell per cycle. The row store is read at the address
// stage and the score is formed and written back in the next cycle; when a
// row is a single column, the new score is forwarded past the memory.
// The score of a last cell passes the scoring stage, then the output queue.
// A two-entry output queue lets the input keep flowing while a score waits;
// the input stalls only when both entries are spoken for and the receiver
// holds out_ready low.
// Reset clears the pipeline, the queue, the column counter and the running
// best, and loads the default register values. The row store is not cleared:
// every entry is written in the first row before any later row reads it.

module local_alignment_binary_matrix (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output      logic                                  in_ready,
  input  wire logic                                  is_match,
  input  wire logic                                  last_cell,
  output      logic                                  out_valid,
  input  wire logic                                  out_ready,
  output      logic [lab_pkg::OUT_BITS-1:0]          best_score,
  input  wire logic                                  cfg_valid,
  output      logic                                  cfg_ready,
  input  wire logic [lab_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [lab_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  import lab_pkg::*;

  // Configuration registers.
  logic [LEN_BITS-1:0]        row_length;
  logic [GAIN_BITS-1:0]       match_gain;
  logic signed [PEN_BITS-1:0] mismatch_penalty;
  logic signed [PEN_BITS-1:0] gap_penalty;

  // Address stage state.
  logic [COL_BITS-1:0]        column_index;
  logic                       on_first_row;

  // Scoring stage.
  lab_item_t                  item;
  logic [SCORE_BITS-1:0]      fwd_score;
  logic [SCORE_BITS-1:0]      ram_q;
  lab_wr_t                    wr;
  lab_result_t                result;

  // Output queue, head in q0.
  logic [OUT_BITS-1:0]        q0;
  logic [OUT_BITS-1:0]        q1;
  logic [1:0]                 q_count;

  logic                       accept;
  logic                       pop;
  logic [LEN_BITS-1:0]        len_eff;
  logic [COL_BITS-1:0]        col_cur;
  logic [LEN_BITS-1:0]        col_inc;
  logic                       row_wrap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length       <= LEN_BITS'(MAX_COLUMNS);
      match_gain       <= GAIN_BITS'(2);
      mismatch_penalty <= -PEN_BITS'(3);
      gap_penalty      <= -PEN_BITS'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_LENGTH:       row_length       <= cfg_data[LEN_BITS-1:0];
        REG_MATCH_GAIN:       match_gain       <= cfg_data[GAIN_BITS-1:0];
        REG_MISMATCH_PENALTY: mismatch_penalty <= signed'(cfg_data[PEN_BITS-1:0]);
        REG_GAP_PENALTY:      gap_penalty      <= signed'(cfg_data[PEN_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // The input is taken whenever the output queue can still absorb the score
  // of a last cell already in the scoring stage plus one more, counting the
  // head entry as free when it leaves in this cycle.
  assign in_ready = (q_count == 2'd0) ||
                    ((q_count == 2'd1) && (!result.push || out_ready)) ||
                    ((q_count == 2'd2) && out_ready);
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // A row length of zero acts as one, and anything above the store depth
  // acts as the full depth. A column beyond a shortened row restarts at zero.
  always_comb begin
    if (row_length == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (row_length > LEN_BITS'(MAX_COLUMNS)) begin
      len_eff = LEN_BITS'(MAX_COLUMNS);
    end else begin
      len_eff = row_length;
    end
    col_cur  = (LEN_BITS'(column_index) >= len_eff) ? '0 : column_index;
    col_inc  = LEN_BITS'(col_cur) + LEN_BITS'(1);
    row_wrap = (col_inc >= len_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      on_first_row <= 1'b1;
    end else if (accept) begin
      if (last_cell) begin
        column_index <= '0;
        on_first_row <= 1'b1;
      end else if (row_wrap) begin
        column_index <= '0;
        on_first_row <= 1'b0;
      end else begin
        column_index <= col_inc[COL_BITS-1:0];
      end
    end
  end

  // The scoring stage writes the entry that this read may target in the same
  // cycle; the memory returns the old word then, so the new score is caught
  // here and used in its place.
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= accept;
    end
    if (accept) begin
      item.col       <= col_cur;
      item.first_row <= on_first_row;
      item.is_match  <= is_match;
      item.last_cell <= last_cell;
      item.fwd       <= wr.we && (wr.addr == col_cur);
      fwd_score      <= wr.data;
    end
  end

  lab_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_row_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (accept),
    .raddr (col_cur),
    .rdata (ram_q)
  );

  lab_pe u_pe (
    .clk              (clk),
    .rst              (rst),
    .item             (item),
    .ram_q            (ram_q),
    .fwd_score        (fwd_score),
    .match_gain       (match_gain),
    .mismatch_penalty (mismatch_penalty),
    .gap_penalty      (gap_penalty),
    .wr               (wr),
    .result           (result)
  );

  // Two-entry output queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else begin
      if (result.push && !pop) begin
        q_count <= q_count + 2'd1;
      end else if (pop && !result.push) begin
        q_count <= q_count - 2'd1;
      end
    end

    if (pop) begin
      if (result.push && (q_count == 2'd1)) begin
        q0 <= result.value;
      end else begin
        q0 <= q1;
      end
      if (result.push && (q_count == 2'd2)) begin
        q1 <= result.value;
      end
    end else if (result.push) begin
      if (q_count == 2'd0) begin
        q0 <= result.value;
      end else begin
        q1 <= result.value;
      end
    end
  end

  assign out_valid  = (q_count != 2'd0);
  assign best_score = q0;

endmodule

`default_nettype wire

// File: rtl/lab_check.sv
`default_nettype none

module lab_check (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         last_cell,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [lab_pkg::OUT_BITS-1:0] best_score
);

  // A stalled score stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_score))
    else $error("best_score changed while stalled");

  // After a last cell is taken, its score reaches the output through the queue.
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_cell |=> ##1 out_valid)
    else $error("no score after last cell");

  // With no score waiting the input never stalls.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind local_alignment_binary_matrix lab_check u_lab_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .last_cell  (last_cell),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .best_score (best_score)
);

`default_nettype wire
